// ----- rtl/fnrw_pkg.sv -----
// Package: widths, job descriptor, op codes and frequency ROM of the FM note register writer.
`timescale 1ns / 1ps
`default_nettype none
package fnrw_pkg;

   localparam int CH_W    = 4;
   localparam int CODE_W  = 8;
   localparam int STEP_W  = 5;
   localparam int NOTE_W  = 4;
   localparam int OCT_W   = 3;
   localparam int FNUM_W  = 10;
   localparam int BYTE_W  = 8;
   localparam int DEPTH_W = 2;
   localparam int PERC_W  = 5;
   localparam int OP_N    = 8;

   localparam int NOTE_ROWS      = 12;
   localparam int STEPS_PER_NOTE = 25;

   localparam logic [CH_W-1:0]    LAST_CH     = 4'd10;
   localparam logic [CH_W-1:0]    FIRST_PERC  = 4'd6;
   localparam logic [CH_W-1:0]    CH_SNARE    = 4'd7;
   localparam logic [CH_W-1:0]    CH_TOM      = 4'd8;
   localparam logic [NOTE_W-1:0]  MAX_NOTE    = 4'd11;
   localparam logic [STEP_W-1:0]  MAX_STEP    = 5'd24;
   localparam logic [NOTE_W-1:0]  FIFTH_WRAP  = 4'd5;
   localparam logic [NOTE_W-1:0]  FIFTH_UP    = 4'd7;
   localparam logic [OCT_W-1:0]   MAX_OCT     = 3'd7;
   localparam logic [BYTE_W-1:0]  ADDR_FLO    = 8'hA0;
   localparam logic [BYTE_W-1:0]  ADDR_FHI    = 8'hB0;
   localparam logic [BYTE_W-1:0]  ADDR_BD     = 8'hBD;

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   typedef logic [FNUM_W-1:0] fnum_type;

   typedef enum logic [0:0] {
      CSR_RHYTHM = 1'b0,
      CSR_DEPTH  = 1'b1
   } csr_idx_type;

   // slot order is emission order
   typedef enum logic [2:0] {
      OP_CLR_A  = 3'd0,
      OP_LO_A   = 3'd1,
      OP_HI_A   = 3'd2,
      OP_CLR_B  = 3'd3,
      OP_LO_B   = 3'd4,
      OP_HI_B   = 3'd5,
      OP_BD_CLR = 3'd6,
      OP_BD_SET = 3'd7
   } op_type;

   typedef struct packed {
      logic              rhythm;
      logic [DEPTH_W-1:0] depth;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0]   ch_a;
      fnum_type          fnum_a;
      logic [OCT_W-1:0]  oct_a;
      fnum_type          fnum_b;
      logic [OCT_W-1:0]  oct_b;
      logic              key_a;
      logic [OP_N-1:0]   ops;
      logic [PERC_W-1:0] perc_bit;
   } job_type;

   localparam logic [PERC_W-1:0] PERC_BIT [PERC_W] = '{5'h10, 5'h08, 5'h04, 5'h02, 5'h01};

   localparam fnum_type FNUM_ROM [NOTE_ROWS][STEPS_PER_NOTE] = '{
      '{10'h157, 10'h158, 10'h159, 10'h15A, 10'h15A, 10'h15B, 10'h15C, 10'h15D, 10'h15E,
        10'h15F, 10'h15F, 10'h160, 10'h161, 10'h162, 10'h163, 10'h164, 10'h164, 10'h165,
        10'h166, 10'h167, 10'h168, 10'h168, 10'h169, 10'h16A, 10'h16B},
      '{10'h16C, 10'h16D, 10'h16D, 10'h16E, 10'h16F, 10'h170, 10'h171, 10'h172, 10'h173,
        10'h174, 10'h174, 10'h175, 10'h176, 10'h177, 10'h178, 10'h179, 10'h17A, 10'h17B,
        10'h17B, 10'h17C, 10'h17D, 10'h17E, 10'h17F, 10'h180, 10'h181},
      '{10'h181, 10'h183, 10'h183, 10'h184, 10'h185, 10'h186, 10'h187, 10'h188, 10'h189,
        10'h18A, 10'h18B, 10'h18C, 10'h18D, 10'h18E, 10'h18E, 10'h18F, 10'h190, 10'h191,
        10'h192, 10'h193, 10'h194, 10'h195, 10'h196, 10'h197, 10'h198},
      '{10'h198, 10'h19A, 10'h19A, 10'h19B, 10'h19C, 10'h19D, 10'h19F, 10'h19F, 10'h1A0,
        10'h1A1, 10'h1A2, 10'h1A3, 10'h1A4, 10'h1A5, 10'h1A6, 10'h1A7, 10'h1A8, 10'h1A9,
        10'h1AA, 10'h1AB, 10'h1AC, 10'h1AD, 10'h1AE, 10'h1AF, 10'h1B0},
      '{10'h1B1, 10'h1B2, 10'h1B3, 10'h1B4, 10'h1B5, 10'h1B6, 10'h1B7, 10'h1B8, 10'h1B9,
        10'h1BA, 10'h1BB, 10'h1BC, 10'h1BD, 10'h1BF, 10'h1C0, 10'h1C1, 10'h1C2, 10'h1C3,
        10'h1C4, 10'h1C5, 10'h1C6, 10'h1C7, 10'h1C8, 10'h1C9, 10'h1CA},
      '{10'h1CB, 10'h1CC, 10'h1CD, 10'h1CE, 10'h1CF, 10'h1D0, 10'h1D2, 10'h1D3, 10'h1D4,
        10'h1D5, 10'h1D6, 10'h1D7, 10'h1D8, 10'h1D9, 10'h1DA, 10'h1DB, 10'h1DD, 10'h1DE,
        10'h1DF, 10'h1E0, 10'h1E1, 10'h1E2, 10'h1E3, 10'h1E4, 10'h1E5},
      '{10'h1E6, 10'h1E8, 10'h1E9, 10'h1EA, 10'h1EB, 10'h1EC, 10'h1ED, 10'h1EF, 10'h1F0,
        10'h1F1, 10'h1F2, 10'h1F3, 10'h1F4, 10'h1F6, 10'h1F7, 10'h1F8, 10'h1F9, 10'h1FA,
        10'h1FB, 10'h1FD, 10'h1FE, 10'h1FF, 10'h200, 10'h201, 10'h202},
      '{10'h203, 10'h205, 10'h206, 10'h207, 10'h208, 10'h20A, 10'h20B, 10'h20C, 10'h20D,
        10'h20F, 10'h210, 10'h211, 10'h212, 10'h214, 10'h215, 10'h216, 10'h217, 10'h219,
        10'h21A, 10'h21B, 10'h21C, 10'h21D, 10'h21F, 10'h220, 10'h221},
      '{10'h222, 10'h224, 10'h225, 10'h226, 10'h227, 10'h229, 10'h22A, 10'h22C, 10'h22D,
        10'h22E, 10'h22F, 10'h231, 10'h232, 10'h234, 10'h235, 10'h236, 10'h237, 10'h239,
        10'h23A, 10'h23B, 10'h23C, 10'h23E, 10'h23F, 10'h241, 10'h242},
      '{10'h243, 10'h245, 10'h246, 10'h247, 10'h248, 10'h24A, 10'h24B, 10'h24D, 10'h24E,
        10'h250, 10'h251, 10'h252, 10'h254, 10'h255, 10'h257, 10'h258, 10'h259, 10'h25B,
        10'h25C, 10'h25E, 10'h25F, 10'h260, 10'h262, 10'h263, 10'h264},
      '{10'h266, 10'h267, 10'h269, 10'h26A, 10'h26B, 10'h26D, 10'h26E, 10'h270, 10'h271,
        10'h273, 10'h274, 10'h276, 10'h277, 10'h279, 10'h27A, 10'h27C, 10'h27D, 10'h27F,
        10'h280, 10'h282, 10'h283, 10'h285, 10'h286, 10'h288, 10'h289},
      '{10'h28A, 10'h28C, 10'h28D, 10'h28F, 10'h291, 10'h292, 10'h294, 10'h295, 10'h297,
        10'h299, 10'h29A, 10'h29C, 10'h29D, 10'h29F, 10'h2A0, 10'h2A2, 10'h2A3, 10'h2A5,
        10'h2A7, 10'h2A8, 10'h2AA, 10'h2AB, 10'h2AD, 10'h2AF, 10'h2B0}
   };

endpackage
`default_nettype wire

// ----- rtl/fnrw_if.sv -----
// Interfaces: note event, register write and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface fnrw_req_if;
   logic                      valid;
   logic                      ready;
   logic [fnrw_pkg::CH_W-1:0]   channel;
   logic [fnrw_pkg::CODE_W-1:0] note_code;
   logic                      hold_key;
   logic [fnrw_pkg::STEP_W-1:0] fine_step;
   logic                      skip_clear;

   modport source (output valid, channel, note_code, hold_key, fine_step, skip_clear,
                   input ready);
   modport sink (input valid, channel, note_code, hold_key, fine_step, skip_clear,
                 output ready);
endinterface

interface fnrw_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fnrw_pkg::BYTE_W-1:0] reg_addr;
   logic [fnrw_pkg::BYTE_W-1:0] reg_value;
   logic                      last_write;

   modport source (output valid, reg_addr, reg_value, last_write, input ready);
   modport sink (input valid, reg_addr, reg_value, last_write, output ready);
endinterface

interface fnrw_csr_if;
   logic                        valid;
   logic                        ready;
   fnrw_pkg::csr_idx_type       index;
   logic [fnrw_pkg::DEPTH_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fm_note_register_writer.sv -----
// The first register write of an event passes through the job queue, the job register and the output register.
// Throughput: one register write per cycle while the output is taken; an event causes 1 to 8 writes,
// and a 2-entry job queue lets events be taken while writes drain.
// Events on channels above ten are accepted and cause no write.
// Reset: synchronous; queue and sequencer empty, percussion keys 0, rhythm 1, depth 3.
`timescale 1ns / 1ps
`default_nettype none
module fm_note_register_writer (
   input  logic         clock,
   input  logic         reset,
   fnrw_req_if.sink     req_chan,
   fnrw_rsp_if.source   rsp_chan,
   fnrw_csr_if.sink     csr_chan
);
   import fnrw_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic               push;
   job_type            push_job;
   job_type            head_job;
   logic               pop;
   logic               q_full;
   logic               q_not_empty;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_RHYTHM: cfg_in.rhythm = csr_chan.data[0];
            CSR_DEPTH:  cfg_in.depth  = csr_chan.data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rhythm <= 1'b1;
         cfg_ff.depth  <= 2'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fnrw_front u_front (
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .push     (push),
      .job      (push_job)
   );

   fnrw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   fnrw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
`default_nettype wire

// ----- rtl/fnrw_front.sv -----
// Front end: accepts note events, clamps, looks up frequencies and builds the write job.
`timescale 1ns / 1ps
`default_nettype none
module fnrw_front (
   fnrw_req_if.sink           req_chan,
   input  fnrw_pkg::cfg_type  cfg,
   input  logic               q_full,
   output logic               push,
   output fnrw_pkg::job_type  job
);
   import fnrw_pkg::*;

   logic [NOTE_W-1:0] note;
   logic [NOTE_W-1:0] note_b;
   logic [STEP_W-1:0] step;
   logic [OCT_W-1:0]  oct;
   logic              off;
   logic              key;
   logic              perc;
   logic              in_range;
   logic              do_a;
   logic              do_b;
   logic [2:0]        perc_idx;

   assign req_chan.ready = !q_full;

   always_comb begin
      note     = (req_chan.note_code[NOTE_W-1:0] > MAX_NOTE) ? MAX_NOTE
                                                              : req_chan.note_code[NOTE_W-1:0];
      step     = (req_chan.fine_step > MAX_STEP) ? MAX_STEP : req_chan.fine_step;
      oct      = req_chan.note_code[NOTE_W +: OCT_W];
      off      = req_chan.note_code[CODE_W-1];
      key      = !req_chan.hold_key && !off;
      in_range = req_chan.channel <= LAST_CH;
      perc     = cfg.rhythm && (req_chan.channel >= FIRST_PERC);
      perc_idx = 3'(req_chan.channel - FIRST_PERC);
      // fifth up, wrapping into the next octave
      note_b   = (note >= FIFTH_WRAP) ? note - FIFTH_WRAP : note + FIFTH_UP;

      do_a = !perc || (req_chan.channel == FIRST_PERC) || ((req_chan.channel == CH_TOM) && !off);
      do_b = perc && (req_chan.channel == CH_TOM) && !off;

      job.ch_a     = req_chan.channel;
      job.fnum_a   = FNUM_ROM[note][step];
      job.oct_a    = oct;
      job.fnum_b   = FNUM_ROM[note_b][step];
      job.oct_b    = ((note >= FIFTH_WRAP) && (oct != MAX_OCT)) ? oct + 3'd1 : oct;
      job.key_a    = key && !perc;
      job.perc_bit = perc ? PERC_BIT[perc_idx] : '0;

      job.ops            = '0;
      job.ops[OP_CLR_A]  = do_a && !req_chan.skip_clear;
      job.ops[OP_LO_A]   = do_a;
      job.ops[OP_HI_A]   = do_a;
      job.ops[OP_CLR_B]  = do_b && !req_chan.skip_clear;
      job.ops[OP_LO_B]   = do_b;
      job.ops[OP_HI_B]   = do_b;
      job.ops[OP_BD_CLR] = perc;
      job.ops[OP_BD_SET] = perc && key;

      // out-of-range channels are accepted and dropped
      push = req_chan.valid && !q_full && in_range;
   end

endmodule
`default_nettype wire

// ----- rtl/fnrw_queue.sv -----
// Job queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module fnrw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fnrw_pkg::job_type  push_job,
   input  logic               pop,
   output fnrw_pkg::job_type  head_job,
   output logic               full,
   output logic               not_empty
);
   import fnrw_pkg::*;

   job_type           mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff;
   logic [Q_AW-1:0]   wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff;
   logic [Q_AW-1:0]   rd_ptr_in;
   logic [Q_CW-1:0]   count_ff;
   logic [Q_CW-1:0]   count_in;

   assign full      = count_ff == Q_CW'(Q_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_job  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CW'(push) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue pushed while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CW'(Q_DEPTH)) else $error("queue count overflow");

endmodule
`default_nettype wire

// ----- rtl/fnrw_back.sv -----
// Back end: steps through a job's writes, keeps the BD shadow and drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module fnrw_back (
   input  logic               clock,
   input  logic               reset,
   input  fnrw_pkg::cfg_type  cfg,
   input  logic               q_not_empty,
   input  fnrw_pkg::job_type  head_job,
   output logic               pop,
   fnrw_rsp_if.source         rsp_chan
);
   import fnrw_pkg::*;

   job_type            job_ff;
   job_type            job_in;
   logic [OP_N-1:0]    mask_ff;
   logic [OP_N-1:0]    mask_in;
   logic [PERC_W-1:0]  keys_ff;
   logic [PERC_W-1:0]  keys_in;
   logic               rsp_v_ff;
   logic               rsp_v_in;
   logic [BYTE_W-1:0]  addr_ff;
   logic [BYTE_W-1:0]  addr_in;
   logic [BYTE_W-1:0]  value_ff;
   logic [BYTE_W-1:0]  value_in;
   logic               last_ff;
   logic               last_in;

   logic               out_free;
   logic               fire;
   logic               load;
   logic [OP_N-1:0]    low_bit;
   logic [OP_N-1:0]    rest;
   op_type             op;

   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.reg_addr   = addr_ff;
   assign rsp_chan.reg_value  = value_ff;
   assign rsp_chan.last_write = last_ff;

   always_comb begin
      out_free = !rsp_v_ff || rsp_chan.ready;
      fire     = (mask_ff != '0) && out_free;
      low_bit  = mask_ff & (~mask_ff + 1'b1);
      rest     = mask_ff & ~low_bit;
      op       = OP_CLR_A;
      for (int i = 0; i < OP_N; i++) begin
         if (low_bit[i]) begin
            op = op_type'(3'(i));
         end
      end
      load = q_not_empty && ((mask_ff == '0) || (fire && (rest == '0)));
      pop  = load;

      keys_in  = keys_ff;
      addr_in  = addr_ff;
      value_in = value_ff;
      last_in  = last_ff;
      if (fire) begin
         last_in = rest == '0;
         unique case (op)
            OP_CLR_A: begin
               addr_in  = ADDR_FHI + BYTE_W'(job_ff.ch_a);
               value_in = '0;
            end
            OP_LO_A: begin
               addr_in  = ADDR_FLO + BYTE_W'(job_ff.ch_a);
               value_in = job_ff.fnum_a[BYTE_W-1:0];
            end
            OP_HI_A: begin
               addr_in  = ADDR_FHI + BYTE_W'(job_ff.ch_a);
               value_in = {2'b00, job_ff.key_a, job_ff.oct_a, job_ff.fnum_a[FNUM_W-1:BYTE_W]};
            end
            OP_CLR_B: begin
               addr_in  = ADDR_FHI + BYTE_W'(CH_SNARE);
               value_in = '0;
            end
            OP_LO_B: begin
               addr_in  = ADDR_FLO + BYTE_W'(CH_SNARE);
               value_in = job_ff.fnum_b[BYTE_W-1:0];
            end
            OP_HI_B: begin
               addr_in  = ADDR_FHI + BYTE_W'(CH_SNARE);
               value_in = {2'b00, 1'b0, job_ff.oct_b, job_ff.fnum_b[FNUM_W-1:BYTE_W]};
            end
            OP_BD_CLR: begin
               keys_in  = keys_ff & ~job_ff.perc_bit;
               addr_in  = ADDR_BD;
               value_in = {cfg.depth, 1'b1, keys_in};
            end
            OP_BD_SET: begin
               keys_in  = keys_ff | job_ff.perc_bit;
               addr_in  = ADDR_BD;
               value_in = {cfg.depth, 1'b1, keys_in};
            end
            default: begin
               addr_in = addr_ff;
            end
         endcase
      end

      if (fire) begin
         rsp_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end

      job_in  = load ? head_job : job_ff;
      if (load) begin
         mask_in = head_job.ops;
      end else if (fire) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      addr_ff  <= addr_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         keys_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         keys_ff  <= keys_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   a_bd_set_bit: assert property (@(posedge clock) disable iff (reset)
      (fire && op == OP_BD_SET) |=> ((keys_ff & $past(job_ff.perc_bit)) == $past(job_ff.perc_bit)))
      else $error("percussion key not set after BD key-on write");
   a_bd_fixed_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && addr_ff == ADDR_BD) |-> value_ff[5]) else $error("BD word lost rhythm bit");
   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != '0 && !fire) |-> !load) else $error("job replaced before its writes finished");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the FM note register writer: directed and random note events, predicted register writes.
`timescale 1ns / 1ps
module tb;
   import fnrw_pkg::*;

   localparam int unsigned IDLE_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [CODE_W-1:0] note_code;
      logic              hold_key;
      logic [STEP_W-1:0] fine_step;
      logic              skip_clear;
   } note_event_type;

   typedef struct packed {
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] value;
      logic              last;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset;

   fnrw_req_if req_chan ();
   fnrw_rsp_if rsp_chan ();
   fnrw_csr_if csr_chan ();

   fm_note_register_writer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic               rhythm_on = 1'b1;
   logic [DEPTH_W-1:0] depth_sel = 2'd3;
   logic [PERC_W-1:0]  drum_keys = '0;

   note_event_type event_backlog [$];
   reg_write_type  expected_writes [$];
   reg_write_type  event_writes [$];

   note_event_type cur_event;
   logic        in_flight = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned req_mode = 1;
   int unsigned rsp_mode = 1;
   int unsigned idle_cycles = 0;
   int unsigned errors = 0;
   int unsigned events_played = 0;
   int unsigned events_ignored = 0;
   int unsigned writes_checked = 0;
   int unsigned bd_writes = 0;
   int unsigned settings_used = 1;

   function automatic int unsigned pick_gap(int unsigned mode);
      int unsigned r;
      if (mode == 0) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic add_write(logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] value);
      reg_write_type w;
      w.addr  = addr;
      w.value = value;
      w.last  = 1'b0;
      event_writes.push_back(w);
   endtask

   task automatic tune_voice(logic [CH_W-1:0] ch, logic [NOTE_W-1:0] note,
                             logic [OCT_W-1:0] oct, logic key, logic [STEP_W-1:0] step,
                             logic skip);
      fnum_type          f;
      logic [BYTE_W-1:0] hi;
      f  = FNUM_ROM[note][step];
      hi = {2'b00, key, oct, f[FNUM_W-1:8]};
      if (!skip) add_write(ADDR_FHI + {4'd0, ch}, 8'h00);
      add_write(ADDR_FLO + {4'd0, ch}, f[7:0]);
      add_write(ADDR_FHI + {4'd0, ch}, hi);
   endtask

   task automatic predict_writes(note_event_type ev);
      logic [NOTE_W-1:0] note;
      logic [NOTE_W-1:0] fifth;
      logic [OCT_W-1:0]  oct;
      logic [OCT_W-1:0]  fifth_oct;
      logic [STEP_W-1:0] step;
      logic [PERC_W-1:0] mask;
      logic              off;
      logic              key;
      reg_write_type     w;
      event_writes.delete();
      if (ev.channel > LAST_CH) begin
         events_ignored++;
         return;
      end
      events_played++;
      note = (ev.note_code[3:0] > MAX_NOTE) ? MAX_NOTE : ev.note_code[3:0];
      oct  = ev.note_code[6:4];
      off  = ev.note_code[7];
      key  = !ev.hold_key && !off;
      step = (ev.fine_step > MAX_STEP) ? MAX_STEP : ev.fine_step;
      if (!rhythm_on || ev.channel < FIRST_PERC) begin
         tune_voice(ev.channel, note, oct, key, step, ev.skip_clear);
      end else begin
         mask = PERC_BIT[int'(ev.channel) - int'(FIRST_PERC)];
         if (ev.channel == FIRST_PERC) begin
            tune_voice(FIRST_PERC, note, oct, 1'b0, step, ev.skip_clear);
         end else if (ev.channel == CH_TOM && !off) begin
            tune_voice(CH_TOM, note, oct, 1'b0, step, ev.skip_clear);
            // fifth up, wrapping into the next octave
            if (note >= FIFTH_WRAP) begin
               fifth     = note - FIFTH_WRAP;
               fifth_oct = (oct == MAX_OCT) ? oct : oct + 3'd1;
            end else begin
               fifth     = note + FIFTH_UP;
               fifth_oct = oct;
            end
            tune_voice(CH_SNARE, fifth, fifth_oct, 1'b0, step, ev.skip_clear);
         end
         drum_keys = drum_keys & ~mask;
         add_write(ADDR_BD, {depth_sel, 1'b1, drum_keys});
         if (key) begin
            drum_keys = drum_keys | mask;
            add_write(ADDR_BD, {depth_sel, 1'b1, drum_keys});
         end
      end
      w = event_writes.pop_back();
      w.last = 1'b1;
      event_writes.push_back(w);
      foreach (event_writes[i]) expected_writes.push_back(event_writes[i]);
   endtask

   // note event driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         in_flight = 1'b0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_writes(cur_event);
            in_flight = 1'b0;
         end
         if (!in_flight) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (event_backlog.size() > 0) begin
               cur_event = event_backlog.pop_front();
               in_flight = 1'b1;
               req_chan.channel    <= cur_event.channel;
               req_chan.note_code  <= cur_event.note_code;
               req_chan.hold_key   <= cur_event.hold_key;
               req_chan.fine_step  <= cur_event.fine_step;
               req_chan.skip_clear <= cur_event.skip_clear;
               req_chan.valid      <= 1'b1;
               req_gap = pick_gap(req_mode);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // register write monitor
   always @(posedge clock) begin
      reg_write_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_writes.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected write, expected none, got addr %02h value %02h",
                        $time, rsp_chan.reg_addr, rsp_chan.reg_value);
            end else begin
               want = expected_writes.pop_front();
               writes_checked++;
               if (want.addr == ADDR_BD) bd_writes++;
               if (rsp_chan.reg_addr !== want.addr) begin
                  errors++;
                  $display("%0t ns: reg_addr expected %02h, got %02h",
                           $time, want.addr, rsp_chan.reg_addr);
               end
               if (rsp_chan.reg_value !== want.value) begin
                  errors++;
                  $display("%0t ns: reg_value at %02h expected %02h, got %02h",
                           $time, want.addr, want.value, rsp_chan.reg_value);
               end
               if (rsp_chan.last_write !== want.last) begin
                  errors++;
                  $display("%0t ns: last_write at %02h expected %0b, got %0b",
                           $time, want.addr, want.last, rsp_chan.last_write);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_stall = pick_gap(rsp_mode);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic note_event_type make_event(logic [CH_W-1:0] ch, logic [CODE_W-1:0] code,
                                                 logic hold, logic [STEP_W-1:0] step,
                                                 logic skip);
      note_event_type ev;
      ev.channel    = ch;
      ev.note_code  = code;
      ev.hold_key   = hold;
      ev.fine_step  = step;
      ev.skip_clear = skip;
      return ev;
   endfunction

   function automatic note_event_type random_event();
      note_event_type ev;
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) ev.channel = CH_W'($urandom_range(15, 11));
      else if (r < 25) ev.channel = CH_TOM;
      else if (r < 55) ev.channel = CH_W'($urandom_range(10, 6));
      else ev.channel = CH_W'($urandom_range(10, 0));
      ev.note_code[3:0] = ($urandom_range(99) < 85) ? NOTE_W'($urandom_range(11, 0))
                                                    : NOTE_W'($urandom_range(15, 12));
      ev.note_code[6:4] = OCT_W'($urandom_range(7, 0));
      ev.note_code[7]   = ($urandom_range(99) < 25);
      ev.hold_key       = ($urandom_range(99) < 20);
      ev.fine_step      = ($urandom_range(99) < 90) ? STEP_W'($urandom_range(24, 0))
                                                    : STEP_W'($urandom_range(31, 25));
      ev.skip_clear     = 1'($urandom_range(1, 0));
      return ev;
   endfunction

   task automatic play_random(int unsigned count, int unsigned req_idle, int unsigned rsp_idle);
      note_event_type ev;
      int unsigned n;
      req_mode = req_idle;
      rsp_mode = rsp_idle;
      n = 0;
      while (n < count) begin
         ev = random_event();
         n++;
         event_backlog.push_back(ev);
      end
   endtask

   task automatic wait_drained();
      while (event_backlog.size() != 0 || in_flight || expected_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [DEPTH_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == CSR_RHYTHM) rhythm_on = value[0];
      else depth_sel = value;
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_mode(logic rhythm, logic [DEPTH_W-1:0] depth);
      wait_drained();
      write_reg(CSR_RHYTHM, {1'b0, rhythm});
      write_reg(CSR_DEPTH, depth);
      settings_used++;
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.channel    = '0;
      req_chan.note_code  = '0;
      req_chan.hold_key   = 1'b0;
      req_chan.fine_step  = '0;
      req_chan.skip_clear = 1'b0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = CSR_RHYTHM;
      csr_chan.data       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // rhythm mode from reset
      req_mode = 0;
      rsp_mode = 0;
      event_backlog.push_back(make_event(4'd0, 8'h00, 1'b0, 5'd0, 1'b0));
      event_backlog.push_back(make_event(4'd5, 8'h7B, 1'b0, 5'd24, 1'b1));
      event_backlog.push_back(make_event(4'd3, 8'h4F, 1'b0, 5'd31, 1'b0));
      event_backlog.push_back(make_event(4'd2, 8'h85, 1'b0, 5'd10, 1'b0));
      event_backlog.push_back(make_event(4'd1, 8'h36, 1'b1, 5'd3, 1'b1));
      event_backlog.push_back(make_event(4'd6, 8'h20, 1'b0, 5'd7, 1'b0));
      event_backlog.push_back(make_event(4'd7, 8'h31, 1'b0, 5'd0, 1'b1));
      event_backlog.push_back(make_event(4'd8, 8'h24, 1'b0, 5'd12, 1'b0));
      event_backlog.push_back(make_event(4'd8, 8'h35, 1'b0, 5'd24, 1'b1));
      event_backlog.push_back(make_event(4'd8, 8'h7B, 1'b0, 5'd5, 1'b0));
      event_backlog.push_back(make_event(4'd8, 8'h7E, 1'b1, 5'd30, 1'b0));
      event_backlog.push_back(make_event(4'd8, 8'h83, 1'b0, 5'd2, 1'b0));
      event_backlog.push_back(make_event(4'd9, 8'h40, 1'b1, 5'd1, 1'b0));
      event_backlog.push_back(make_event(4'd10, 8'h11, 1'b0, 5'd9, 1'b1));
      event_backlog.push_back(make_event(4'd6, 8'hF3, 1'b0, 5'd4, 1'b0));
      event_backlog.push_back(make_event(4'd11, 8'h22, 1'b0, 5'd4, 1'b0));
      event_backlog.push_back(make_event(4'd15, 8'hFF, 1'b1, 5'd31, 1'b1));
      event_backlog.push_back(make_event(4'd9, 8'h52, 1'b0, 5'd20, 1'b1));
      play_random(70, 1, 1);

      // melodic mode, all channels up to ten get frequency writes
      set_mode(1'b0, 2'd0);
      event_backlog.push_back(make_event(4'd6, 8'h60, 1'b0, 5'd8, 1'b0));
      event_backlog.push_back(make_event(4'd7, 8'h1C, 1'b0, 5'd14, 1'b1));
      event_backlog.push_back(make_event(4'd8, 8'h7B, 1'b0, 5'd24, 1'b0));
      event_backlog.push_back(make_event(4'd9, 8'hA2, 1'b0, 5'd3, 1'b0));
      event_backlog.push_back(make_event(4'd10, 8'h45, 1'b1, 5'd17, 1'b1));
      play_random(70, 0, 0);

      // back to rhythm mode, drum keys carried over
      set_mode(1'b1, 2'd0);
      play_random(75, 1, 0);
      set_mode(1'b1, 2'd2);
      play_random(75, 0, 1);
      set_mode(1'b0, 2'd3);
      play_random(70, 1, 1);
      set_mode(1'b1, 2'd1);
      play_random(75, 1, 1);
      wait_drained();

      $display("Played %0d note events (%0d on unused channels) under %0d settings;",
               events_played, events_ignored, settings_used);
      $display("checked %0d register writes, %0d of them to BD.", writes_checked, bd_writes);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
